// ===== rtl/core/prce_pkg.sv =====
// Shared types and constants for the programmable reflected CRC engine.
`default_nettype none

package prce_pkg;

  localparam int CRC_W  = 16;
  localparam int BYTE_W = 8;
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;
  localparam int REG_IW = 2;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IW-1:0] REG_WIDTH_MODE = 2'd0;
  localparam logic [REG_IW-1:0] REG_POLY       = 2'd1;
  localparam logic [REG_IW-1:0] REG_START      = 2'd2;

  localparam logic             RST_WIDE  = 1'b1;
  localparam logic [CRC_W-1:0] RST_POLY  = 16'h1021;
  localparam logic [CRC_W-1:0] RST_START = 16'hFFFF;

  typedef struct packed {
    logic             wide;
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] start;
  } prce_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/prce_in_if.sv =====
// Byte input channel of the CRC engine.
`default_nettype none

interface prce_in_if import prce_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;
  logic              last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/prce_out_if.sv =====
// CRC result channel of the CRC engine.
`default_nettype none

interface prce_out_if import prce_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CRC_W-1:0] crc_value;
  logic             message_done;

  modport source (output valid, crc_value, message_done, input ready);
  modport sink   (input valid, crc_value, message_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/programmable_reflected_crc_engine_top.sv =====
// Top level of the programmable reflected CRC engine.
// Usage:
//   in_ch  : one message byte per transfer, with first_byte/last_byte flags.
//            first_byte reloads the programmed start value before the byte.
//   out_ch : one result per input byte: running CRC after that byte, and
//            message_done echoing last_byte (final CRC when set).
//   cfg_*  : APB registers at 0x0 width mode (1 = CRC16, 0 = CRC8),
//            0x4 polynomial (normal order), 0x8 start value. Write them only
//            while no byte is in flight.
// Path: an accepted byte passes two registers, the input stage and then the
//   result stage, whose outputs drive out_ch.
// Throughput: one byte per cycle while out_ch is not held; the eight shift/XOR
//   steps of the fold unit sit between the input stage and the result stage.
// Stall: when out_ch is held, the result register holds, the input stage
//   still takes one more byte, then in_ch.ready drops until out_ch drains.
// Reset: both stages empty, running CRC = 0, registers at CRC16, 0x1021,
//   0xFFFF. No final XOR is applied; in CRC8 mode the upper byte reads 0.
`default_nettype none

module programmable_reflected_crc_engine_top import prce_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  prce_in_if.sink                in_ch,
  prce_out_if.source             out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [APB_AW-1:0] cfg_paddr,
  input  wire logic [APB_DW-1:0] cfg_pwdata,
  output      logic [APB_DW-1:0] cfg_prdata,
  output      logic              cfg_pready
);

  prce_cfg_t cfg;

  // input stage
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_first_r;
  logic              s1_last_r;

  // result stage; out_crc_r doubles as the running CRC state
  logic             out_valid_r;
  logic [CRC_W-1:0] out_crc_r;
  logic             out_done_r;

  logic             s2_free;
  logic             s1_adv;
  logic [CRC_W-1:0] crc_nxt;

  prce_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  prce_fold u_fold (
    .cfg        (cfg),
    .crc_prev   (out_crc_r),
    .data_byte  (s1_data_r),
    .first_byte (s1_first_r),
    .crc_next   (crc_nxt)
  );

  // Result stage frees up when empty or when its transfer completes.
  assign s2_free     = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && s2_free;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_data_r  <= in_ch.data_byte;
      s1_first_r <= in_ch.first_byte;
      s1_last_r  <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_crc_r   <= '0;
    end else begin
      if (s2_free) out_valid_r <= s1_valid_r;
      if (s1_adv)  out_crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_done_r <= s1_last_r;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.crc_value    = out_crc_r;
  assign out_ch.message_done = out_done_r;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced byte did not reach result stage");

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while both stages full and stalled");

  a_stall_holds_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_crc_r) && $stable(out_done_r))
    else $error("running CRC changed during output stall");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/prce_cfg_regs.sv =====
// APB configuration registers: width mode, polynomial, start value.
`default_nettype none

module prce_cfg_regs import prce_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready,
  output      prce_cfg_t         cfg
);

  prce_cfg_t         cfg_r;
  logic              wr_en;
  logic [REG_IW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[REG_IW+1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide  <= RST_WIDE;
      cfg_r.poly  <= RST_POLY;
      cfg_r.start <= RST_START;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH_MODE: cfg_r.wide  <= pwdata[0];
        REG_POLY:       cfg_r.poly  <= pwdata[CRC_W-1:0];
        REG_START:      cfg_r.start <= pwdata[CRC_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH_MODE: prdata = {{(APB_DW-1){1'b0}}, cfg_r.wide};
      REG_POLY:       prdata = {{(APB_DW-CRC_W){1'b0}}, cfg_r.poly};
      REG_START:      prdata = {{(APB_DW-CRC_W){1'b0}}, cfg_r.start};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/prce_fold.sv =====
// One-byte reflected CRC update: seed select, byte XOR, eight shift/XOR steps.
`default_nettype none

module prce_fold import prce_pkg::*; (
  input  wire prce_cfg_t         cfg,
  input  wire logic [CRC_W-1:0]  crc_prev,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              first_byte,
  output      logic [CRC_W-1:0]  crc_next
);

  logic [CRC_W-1:0] rpoly;
  logic [CRC_W-1:0] crc_v;

  // Polynomial is programmed in normal order; reflect over the active width.
  always_comb begin
    rpoly = '0;
    if (cfg.wide) begin
      for (int i = 0; i < CRC_W; i++) rpoly[CRC_W-1-i] = cfg.poly[i];
    end else begin
      for (int i = 0; i < BYTE_W; i++) rpoly[BYTE_W-1-i] = cfg.poly[i];
    end
  end

  always_comb begin
    crc_v = first_byte ? cfg.start : crc_prev;
    if (!cfg.wide) crc_v[CRC_W-1:BYTE_W] = '0;
    crc_v[BYTE_W-1:0] = crc_v[BYTE_W-1:0] ^ data_byte;
    for (int k = 0; k < BYTE_W; k++) begin
      if (crc_v[0]) crc_v = {1'b0, crc_v[CRC_W-1:1]} ^ rpoly;
      else          crc_v = {1'b0, crc_v[CRC_W-1:1]};
    end
    // rpoly upper byte is zero in 8-bit mode, so the result stays 8 bits there
    crc_next = crc_v;
  end

endmodule

`default_nettype wire
